// ===== hw/rtl/dpl_pkg.sv =====
package dpl_pkg;

    // Field widths
    localparam int TACHO_W   = 32;
    localparam int DPC_W     = 24;
    localparam int ODO_W     = TACHO_W + DPC_W;   // Q16 odometry product
    localparam int ODO_CM_W  = ODO_W - 16;        // whole centimetres
    localparam int QSUM_W    = ODO_CM_W + 1;      // odometry plus look-ahead
    localparam int LAP_W     = 16;
    localparam int PCOUNT_W  = 11;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 24;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIST_PER_COUNT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_SPACING = 8'd1;

    typedef enum logic [2:0] {
        OP_START_LEARN = 3'd0,
        OP_LEARN_TICK  = 3'd1,
        OP_STOP        = 3'd2,
        OP_START_RACE  = 3'd3,
        OP_QUERY       = 3'd4,
        OP_CLEAR       = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_LEARN = 2'd1,
        MODE_RACE  = 2'd2
    } mode_t;

    typedef struct packed {
        logic [2:0]         op;
        logic [31:0]        tacho_count;
        logic signed [15:0] steer_command;
        logic signed [15:0] target_speed_q8;
        logic [15:0]        lookahead_cm;
    } item_t;

    typedef struct packed {
        logic [7:0]          speed_tenths;
        logic                speed_valid;
        logic                accepted;
        logic [1:0]          mode_now;
        logic [PCOUNT_W-1:0] point_count;
        logic [15:0]         lap_length_cm;
    } result_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] reg_index;
        logic [CFG_DAT_W-1:0] wdata;
    } cfg_t;

    // steer / 8 toward zero, clamped to +-125, as 8-bit two's complement
    function automatic logic [7:0] steer_pack(input logic signed [15:0] steer);
        logic signed [16:0] biased;
        logic signed [16:0] q;
        logic [7:0]         res;
        biased = steer[15] ? ({steer[15], steer} + 17'sd7) : {steer[15], steer};
        q = biased >>> 3;
        if (q > 17'sd125)
            res = 8'd125;
        else if (q < -17'sd125)
            res = 8'h83;
        else
            res = q[7:0];
        return res;
    endfunction

    // speed * 10 / 256 toward zero, clamped to 0..255
    function automatic logic [7:0] speed_pack(input logic signed [15:0] sp);
        logic [18:0] t;
        logic [10:0] v;
        logic [7:0]  res;
        t = ({4'b0, sp[14:0]} << 3) + ({4'b0, sp[14:0]} << 1);
        v = t[18:8];
        if (sp[15] || sp == 16'sd0)
            res = 8'd0;
        else if (v > 11'd255)
            res = 8'd255;
        else
            res = v[7:0];
        return res;
    endfunction

    // Q16 odometry to centimetres, saturated to 16 bits
    function automatic logic [LAP_W-1:0] sat16_cm(input logic [ODO_W-1:0] d);
        logic [LAP_W-1:0] res;
        if (d[ODO_W-1:32] != '0)
            res = '1;
        else
            res = d[31:16];
        return res;
    endfunction

endpackage

// ===== hw/rtl/dpl_item_if.sv =====
interface dpl_item_if;
    logic           valid;
    logic           ready;
    dpl_pkg::item_t req;

    modport source (output valid, output req, input ready);
    modport sink   (input valid, input req, output ready);
endinterface

// ===== hw/rtl/dpl_result_if.sv =====
interface dpl_result_if;
    logic             valid;
    logic             ready;
    dpl_pkg::result_t req;

    modport source (output valid, output req, input ready);
    modport sink   (input valid, input req, output ready);
endinterface

// ===== hw/rtl/dpl_cfg_if.sv =====
interface dpl_cfg_if;
    logic          valid;
    logic          ready;
    dpl_pkg::cfg_t req;

    modport source (output valid, output req, input ready);
    modport sink   (input valid, input req, output ready);
endinterface

// ===== hw/rtl/dpl_point_mem.sv =====
module dpl_point_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [31:0]   wdata,
    output logic [31:0]   rdata
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;

    // single port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/dpl_rem_unit.sv =====
module dpl_rem_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [dpl_pkg::QSUM_W-1:0]  dividend,
    input  logic [dpl_pkg::LAP_W-1:0]   divisor,
    output logic                        done,
    output logic [dpl_pkg::LAP_W-1:0]   rem
);
    import dpl_pkg::*;

    localparam int CW = $clog2(QSUM_W + 1);

    logic              busy_reg,  busy_next;
    logic              done_reg,  done_next;
    logic [CW-1:0]     cnt_reg,   cnt_next;
    logic [QSUM_W-1:0] dvd_reg,   dvd_next;
    logic [LAP_W-1:0]  dvs_reg,   dvs_next;
    logic [LAP_W-1:0]  rem_reg,   rem_next;
    logic [LAP_W:0]    trial;

    // one restoring step per cycle, dividend MSB first
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, dvd_reg[QSUM_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(QSUM_W);
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
                rem_next = LAP_W'(trial - {1'b0, dvs_reg});
            else
                rem_next = trial[LAP_W-1:0];
            dvd_next = dvd_reg << 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// ===== hw/rtl/distance_profile_learn_and_lookup_unit.sv =====
// Channel  | Modport | Moves                            | Handshake
// item     | sink    | op, tacho, steer, speed, lookahd | valid/ready
// result   | source  | speed, valid, accepted, state    | valid/ready
// cfg      | sink    | register index, write data       | valid/ready, ready always high
//
// Control ops pass through capture, odometry multiply, execute and output register load.
// A speed query adds the lap remainder (41 bits, one per cycle), a binary search with a
// probe state and a compare state per probe (about log2 of the point count probes), a step to
// close the search and a read and a compare per window entry (up to 2*WINDOW_HALF+1 entries).
// Reset is asynchronous; the point memory is not cleared and needs no sweep.
// A new request is taken while the previous result still waits in the output register.
module distance_profile_learn_and_lookup_unit #(
    parameter int MAX_POINTS  = 1024,
    parameter int WINDOW_HALF = 3
) (
    input  logic       clk,
    input  logic       rst_n,
    dpl_item_if.sink   item,
    dpl_result_if.source result,
    dpl_cfg_if.sink    cfg
);
    import dpl_pkg::*;

    localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int EW    = $clog2(MAX_POINTS + WINDOW_HALF + 1) + 1;

    typedef enum logic [8:0] {
        S_WAIT = 9'b000000001,
        S_MUL  = 9'b000000010,
        S_EXEC = 9'b000000100,
        S_REM  = 9'b000001000,
        S_BS   = 9'b000010000,
        S_BSW  = 9'b000100000,
        S_WIN  = 9'b001000000,
        S_WINW = 9'b010000000,
        S_DONE = 9'b100000000
    } state_t;

    state_t            state_reg,  state_next;
    item_t             item_reg,   item_next;
    logic [ODO_W-1:0]  prod_reg,   prod_next;
    mode_t             mode_reg,   mode_next;
    logic [CNT_W-1:0]  cnt_reg,    cnt_next;
    logic [LAP_W-1:0]  lap_reg,    lap_next;
    logic [31:0]       start_reg,  start_next;
    logic [ODO_W-1:0]  last_reg,   last_next;
    logic [DPC_W-1:0]  dpc_reg,    dpc_next;
    logic [7:0]        space_reg,  space_next;
    logic [LAP_W-1:0]  qcm_reg,    qcm_next;
    logic [AW-1:0]     lo_reg,     lo_next;
    logic [AW-1:0]     hi_reg,     hi_next;
    logic [AW-1:0]     mid_reg,    mid_next;
    logic [AW-1:0]     idx_reg,    idx_next;
    logic [AW-1:0]     lastix_reg, lastix_next;
    logic [8:0]        best_reg,   best_next;
    logic [7:0]        speed_reg,  speed_next;
    logic              svalid_reg, svalid_next;
    logic              acc_reg,    acc_next;
    logic              ovalid_reg, ovalid_next;
    result_t           out_reg,    out_next;

    // memory and remainder unit hookup
    logic              mem_we;
    logic [AW-1:0]     mem_addr;
    logic [31:0]       mem_wdata;
    logic [31:0]       mem_rdata;
    logic              rem_start;
    logic              rem_done;
    logic [LAP_W-1:0]  rem_val;
    logic [QSUM_W-1:0] qsum;

    // helpers
    logic [31:0]       counts;
    logic [ODO_W-1:0]  diff;
    logic [ODO_W-1:0]  need;
    logic [CNT_W-1:0]  cnt_m1;
    logic [AW:0]       mid_sum;
    logic [EW-1:0]     lo_ext;
    logic [EW-1:0]     lo_plus;
    logic [EW-1:0]     lo_minus;
    logic [EW-1:0]     cnt_m1_ext;
    logic [7:0]        win_s;
    logic [8:0]        best_upd;
    logic [CNT_W+PCOUNT_W-1:0] cnt_wide;

    assign counts     = item_reg.tacho_count - start_reg;
    assign diff       = prod_reg - last_reg;
    assign need       = {{(ODO_W-24){1'b0}}, space_reg, 16'b0};
    assign cnt_m1     = cnt_reg - 1'b1;
    assign mid_sum    = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign lo_ext     = EW'(lo_reg);
    assign lo_plus    = lo_ext + EW'(WINDOW_HALF);
    assign lo_minus   = lo_ext - EW'(WINDOW_HALF);
    assign cnt_m1_ext = EW'(cnt_m1);
    assign qsum       = {1'b0, prod_reg[ODO_W-1:16]} + QSUM_W'(item_reg.lookahead_cm);
    assign win_s      = mem_rdata[31:24];
    assign best_upd   = (win_s != 8'd0 && {1'b0, win_s} < best_reg) ? {1'b0, win_s}
                                                                     : best_reg;
    assign cnt_wide   = {{PCOUNT_W{1'b0}}, cnt_reg};

    dpl_point_mem #(
        .DEPTH (MAX_POINTS),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    dpl_rem_unit u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (qsum),
        .divisor  (lap_reg),
        .done     (rem_done),
        .rem      (rem_val)
    );

    assign item.ready   = (state_reg == S_WAIT);
    assign cfg.ready    = 1'b1;
    assign result.valid = ovalid_reg;
    assign result.req   = out_reg;

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        item_next   = item_reg;
        prod_next   = prod_reg;
        mode_next   = mode_reg;
        cnt_next    = cnt_reg;
        lap_next    = lap_reg;
        start_next  = start_reg;
        last_next   = last_reg;
        dpc_next    = dpc_reg;
        space_next  = space_reg;
        qcm_next    = qcm_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        idx_next    = idx_reg;
        lastix_next = lastix_reg;
        best_next   = best_reg;
        speed_next  = speed_reg;
        svalid_next = svalid_reg;
        acc_next    = acc_reg;
        ovalid_next = ovalid_reg;
        out_next    = out_reg;
        mem_we      = 1'b0;
        mem_addr    = cnt_reg[AW-1:0];
        mem_wdata   = {speed_pack(item_reg.target_speed_q8),
                       steer_pack(item_reg.steer_command),
                       sat16_cm(prod_reg)};
        rem_start   = 1'b0;

        // register writes
        if (cfg.valid)
        begin
            if (cfg.req.reg_index == CFG_DIST_PER_COUNT)
                dpc_next = cfg.req.wdata;
            else if (cfg.req.reg_index == CFG_SAMPLE_SPACING)
                space_next = cfg.req.wdata[7:0];
        end

        // result drained
        if (ovalid_reg && result.ready)
            ovalid_next = 1'b0;

        unique case (state_reg)
            S_WAIT:
            begin
                if (item.valid)
                begin
                    item_next  = item.req;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                prod_next  = ODO_W'(counts) * ODO_W'(dpc_reg);
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                speed_next  = 8'd0;
                svalid_next = 1'b0;
                acc_next    = 1'b0;
                state_next  = S_DONE;
                unique case (item_reg.op)
                    OP_START_LEARN:
                    begin
                        mode_next  = MODE_LEARN;
                        cnt_next   = '0;
                        lap_next   = '0;
                        start_next = item_reg.tacho_count;
                        last_next  = '0;
                        acc_next   = 1'b1;
                    end
                    OP_LEARN_TICK:
                    begin
                        if (mode_reg == MODE_LEARN && prod_reg >= last_reg
                            && diff >= need && cnt_reg < CNT_W'(MAX_POINTS))
                        begin
                            mem_we    = 1'b1;
                            cnt_next  = cnt_reg + 1'b1;
                            last_next = prod_reg;
                            acc_next  = 1'b1;
                        end
                    end
                    OP_STOP:
                    begin
                        if (mode_reg == MODE_LEARN)
                        begin
                            lap_next  = sat16_cm(prod_reg);
                            mode_next = MODE_IDLE;
                            acc_next  = 1'b1;
                        end
                        else if (mode_reg == MODE_RACE)
                        begin
                            mode_next = MODE_IDLE;
                            acc_next  = 1'b1;
                        end
                    end
                    OP_START_RACE:
                    begin
                        if (cnt_reg >= CNT_W'(2))
                        begin
                            mode_next  = MODE_RACE;
                            start_next = item_reg.tacho_count;
                            acc_next   = 1'b1;
                        end
                    end
                    OP_QUERY:
                    begin
                        if (mode_reg == MODE_RACE && cnt_reg >= CNT_W'(2)
                            && lap_reg != '0)
                        begin
                            rem_start  = 1'b1;
                            state_next = S_REM;
                        end
                    end
                    OP_CLEAR:
                    begin
                        mode_next = MODE_IDLE;
                        cnt_next  = '0;
                        lap_next  = '0;
                        acc_next  = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_REM:
            begin
                if (rem_done)
                begin
                    qcm_next   = rem_val;
                    lo_next    = '0;
                    hi_next    = cnt_m1[AW-1:0];
                    state_next = S_BS;
                end
            end
            S_BS:
            begin
                // lower-bound search; a probe sets the address here and compares in S_BSW
                if (lo_reg < hi_reg)
                begin
                    mid_next   = mid_sum[AW:1];
                    mem_addr   = mid_sum[AW:1];
                    state_next = S_BSW;
                end
                else
                begin
                    idx_next    = (lo_ext > EW'(WINDOW_HALF)) ? lo_minus[AW-1:0] : '0;
                    lastix_next = (lo_plus > cnt_m1_ext) ? cnt_m1[AW-1:0]
                                                         : lo_plus[AW-1:0];
                    best_next   = 9'd256;
                    state_next  = S_WIN;
                end
            end
            S_BSW:
            begin
                if (mem_rdata[15:0] < qcm_reg)
                    lo_next = mid_reg + 1'b1;
                else
                    hi_next = mid_reg;
                state_next = S_BS;
            end
            S_WIN:
            begin
                mem_addr   = idx_reg;
                state_next = S_WINW;
            end
            S_WINW:
            begin
                // minimum nonzero speed over the window
                best_next = best_upd;
                if (idx_reg == lastix_reg)
                begin
                    speed_next  = best_upd[8] ? 8'd0 : best_upd[7:0];
                    svalid_next = !best_upd[8];
                    acc_next    = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_WIN;
                end
            end
            S_DONE:
            begin
                if (!ovalid_reg || result.ready)
                begin
                    out_next.speed_tenths  = speed_reg;
                    out_next.speed_valid   = svalid_reg;
                    out_next.accepted      = acc_reg;
                    out_next.mode_now      = mode_reg;
                    out_next.point_count   = cnt_wide[PCOUNT_W-1:0];
                    out_next.lap_length_cm = lap_reg;
                    ovalid_next            = 1'b1;
                    state_next             = S_WAIT;
                end
            end
            default:
            begin
                state_next = S_WAIT;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_WAIT;
            mode_reg   <= MODE_IDLE;
            cnt_reg    <= '0;
            lap_reg    <= '0;
            start_reg  <= '0;
            last_reg   <= '0;
            dpc_reg    <= '0;
            space_reg  <= 8'd10;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            mode_reg   <= mode_next;
            cnt_reg    <= cnt_next;
            lap_reg    <= lap_next;
            start_reg  <= start_next;
            last_reg   <= last_next;
            dpc_reg    <= dpc_next;
            space_reg  <= space_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // working payload
    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        prod_reg   <= prod_next;
        qcm_reg    <= qcm_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        idx_reg    <= idx_next;
        lastix_reg <= lastix_next;
        best_reg   <= best_next;
        speed_reg  <= speed_next;
        svalid_reg <= svalid_next;
        acc_reg    <= acc_next;
        out_reg    <= out_next;
    end

endmodule

// ===== sim/distance_profile_learn_and_lookup_unit_test.sv =====
module distance_profile_learn_and_lookup_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dpl_pkg::*;

    localparam int PROF_DEPTH   = 1024;
    localparam int PROF_WINDOW  = 3;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int SETTLE_CYCLES = 100;
    localparam int PRINT_CAP    = 50;

    logic clk;
    logic rst_n;

    dpl_item_if   item_ch();
    dpl_result_if result_ch();
    dpl_cfg_if    cfg_ch();

    distance_profile_learn_and_lookup_unit #(
        .MAX_POINTS  (PROF_DEPTH),
        .WINDOW_HALF (PROF_WINDOW)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // Requests waiting to be driven and results still owed by the block
    item_t   queued_reqs[$];
    result_t due_results[$];
    int unsigned queued_count;
    int unsigned taken_count;
    int unsigned err_count;
    int unsigned cycle_count;
    int unsigned gap_pct;
    int unsigned item_gap;
    int unsigned ready_hold;

    // Profile model state and register copies
    mode_t       prof_mode;
    logic [31:0] prof_mem [0:PROF_DEPTH-1];
    logic [10:0] prof_count;
    logic [15:0] prof_lap;
    logic [31:0] prof_start;
    logic [55:0] prof_last;
    logic [23:0] dpc_cfg;
    logic [7:0]  spacing_cfg;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Run watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (r >= gap_pct)
            return 0;
        if ($urandom_range(99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Q16 odometry from the current start count
    function automatic logic [55:0] odometry(input logic [31:0] tacho);
        logic [31:0] counts;
        counts = tacho - prof_start;
        return {24'b0, counts} * {32'b0, dpc_cfg};
    endfunction

    function automatic logic [15:0] sat_cm(input logic [55:0] d);
        if (d[55:32] != '0)
            return 16'hFFFF;
        return d[31:16];
    endfunction

    // Advance the profile model by one request and return the result it owes
    function automatic result_t profile_step(input item_t it);
        result_t     r;
        logic [55:0] odo;
        logic [56:0] qsum;
        logic [56:0] lap_q16;
        logic [56:0] rem;
        logic [15:0] qcm;
        int          s;
        int          sp;
        int          spd;
        int          lo;
        int          hi;
        int          mid;
        int          first;
        int          last;
        int          best;
        int          i;
        r = '0;
        odo = odometry(it.tacho_count);
        case (it.op)
            OP_START_LEARN:
            begin
                prof_mode = MODE_LEARN;
                prof_count = '0;
                prof_lap = '0;
                prof_start = it.tacho_count;
                prof_last = '0;
                r.accepted = 1'b1;
            end
            OP_LEARN_TICK:
            begin
                if (prof_mode == MODE_LEARN && odo >= prof_last
                    && odo - prof_last >= {32'b0, spacing_cfg, 16'b0}
                    && prof_count < PROF_DEPTH)
                begin
                    s = $signed(it.steer_command);
                    s = s / 8;
                    if (s > 125)
                        s = 125;
                    if (s < -125)
                        s = -125;
                    sp = $signed(it.target_speed_q8);
                    if (sp <= 0)
                        spd = 0;
                    else
                    begin
                        spd = (sp * 10) / 256;
                        if (spd > 255)
                            spd = 255;
                    end
                    prof_mem[prof_count] = {spd[7:0], s[7:0], sat_cm(odo)};
                    prof_count = prof_count + 11'd1;
                    prof_last = odo;
                    r.accepted = 1'b1;
                end
            end
            OP_STOP:
            begin
                if (prof_mode == MODE_LEARN)
                begin
                    prof_lap = sat_cm(odo);
                    prof_mode = MODE_IDLE;
                    r.accepted = 1'b1;
                end
                else if (prof_mode == MODE_RACE)
                begin
                    prof_mode = MODE_IDLE;
                    r.accepted = 1'b1;
                end
            end
            OP_START_RACE:
            begin
                if (prof_count >= 2)
                begin
                    prof_mode = MODE_RACE;
                    prof_start = it.tacho_count;
                    r.accepted = 1'b1;
                end
            end
            OP_QUERY:
            begin
                if (prof_mode == MODE_RACE && prof_count >= 2 && prof_lap != '0)
                begin
                    r.accepted = 1'b1;
                    qsum = {1'b0, odo} + {25'b0, it.lookahead_cm, 16'b0};
                    lap_q16 = {25'b0, prof_lap, 16'b0};
                    rem = qsum % lap_q16;
                    qcm = rem[31:16];
                    // lower bound on stored distance
                    lo = 0;
                    hi = prof_count - 1;
                    while (lo < hi)
                    begin
                        mid = (lo + hi) / 2;
                        if (prof_mem[mid][15:0] < qcm)
                            lo = mid + 1;
                        else
                            hi = mid;
                    end
                    first = (lo > PROF_WINDOW) ? lo - PROF_WINDOW : 0;
                    last = lo + PROF_WINDOW;
                    if (last > prof_count - 1)
                        last = prof_count - 1;
                    // slowest nonzero speed around that point
                    best = 256;
                    for (i = first; i <= last; i++)
                    begin
                        if (prof_mem[i][31:24] != 8'd0 && prof_mem[i][31:24] < best)
                            best = prof_mem[i][31:24];
                    end
                    if (best < 256)
                    begin
                        r.speed_tenths = best[7:0];
                        r.speed_valid = 1'b1;
                    end
                end
            end
            OP_CLEAR:
            begin
                prof_mode = MODE_IDLE;
                prof_count = '0;
                prof_lap = '0;
                r.accepted = 1'b1;
            end
            default:
            begin
            end
        endcase
        r.mode_now = prof_mode;
        r.point_count = prof_count;
        r.lap_length_cm = prof_lap;
        return r;
    endfunction

    task automatic report(input string what, input longint unsigned got,
                          input longint unsigned want);
        if (err_count < PRINT_CAP)
            $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
        err_count++;
    endtask

    task automatic check_result(input result_t got);
        result_t want;
        if (due_results.size() == 0)
            report("result with no request pending", got, 0);
        else
        begin
            want = due_results.pop_front();
            if (got.speed_tenths !== want.speed_tenths)
                report("speed_tenths", got.speed_tenths, want.speed_tenths);
            if (got.speed_valid !== want.speed_valid)
                report("speed_valid", got.speed_valid, want.speed_valid);
            if (got.accepted !== want.accepted)
                report("accepted", got.accepted, want.accepted);
            if (got.mode_now !== want.mode_now)
                report("mode_now", got.mode_now, want.mode_now);
            if (got.point_count !== want.point_count)
                report("point_count", got.point_count, want.point_count);
            if (got.lap_length_cm !== want.lap_length_cm)
                report("lap_length_cm", got.lap_length_cm, want.lap_length_cm);
        end
    endtask

    // Request driver: predicts on acceptance, then loads the next request
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            item_ch.valid <= 1'b0;
            item_gap <= 0;
        end
        else
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                due_results.push_back(profile_step(item_ch.req));
                taken_count++;
            end
            if (!item_ch.valid || item_ch.ready)
            begin
                if (item_gap > 0)
                begin
                    item_ch.valid <= 1'b0;
                    item_gap <= item_gap - 1;
                end
                else if (queued_reqs.size() > 0)
                begin
                    item_ch.req <= queued_reqs.pop_front();
                    item_ch.valid <= 1'b1;
                    item_gap <= pick_gap();
                end
                else
                    item_ch.valid <= 1'b0;
            end
        end
    end

    // Result monitor with random back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            ready_hold <= 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
                check_result(result_ch.req);
            if (ready_hold > 0)
            begin
                result_ch.ready <= 1'b0;
                ready_hold <= ready_hold - 1;
            end
            else
            begin
                result_ch.ready <= 1'b1;
                ready_hold <= pick_gap();
            end
        end
    end

    task automatic push_req(input op_t op, input logic [31:0] tacho, input logic [15:0] steer,
                            input logic [15:0] speed, input logic [15:0] look);
        item_t it;
        it.op = op;
        it.tacho_count = tacho;
        it.steer_command = steer;
        it.target_speed_q8 = speed;
        it.lookahead_cm = look;
        queued_reqs.push_back(it);
        queued_count++;
    endtask

    // Random 16-bit field value
    function automatic logic [15:0] pick_word();
        return 16'($urandom);
    endfunction

    task automatic push_noise();
        push_req(op_t'($urandom_range(0, 5)), $urandom, pick_word(), pick_word(), pick_word());
    endtask

    function automatic logic [15:0] pick_speed(input bit no_speed);
        int unsigned r;
        r = $urandom_range(99);
        if (no_speed || r < 12)
            return 16'h0;
        if (r < 80)
            return 16'($urandom_range(1, 7000));
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] pick_look();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 20)
            return 16'h0;
        if (r < 60)
            return 16'($urandom_range(0, 300));
        return 16'($urandom);
    endfunction

    // Wait until every request has been taken and answered
    task automatic wait_drain();
        while (taken_count != queued_count || due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        @(posedge clk);
        cfg_ch.req <= '{reg_index: idx, wdata: val};
        cfg_ch.valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == CFG_DIST_PER_COUNT)
            dpc_cfg = val;
        else if (idx == CFG_SAMPLE_SPACING)
            spacing_cfg = val[7:0];
    endtask

    // One learn lap followed by a race with look-ahead queries
    task automatic queue_session(input int unsigned n_ticks, input int unsigned n_queries);
        logic [31:0]     t0;
        logic [31:0]     t;
        logic [31:0]     r0;
        logic [31:0]     travel;
        logic [31:0]     tq;
        longint unsigned base;
        longint unsigned reach;
        bit              no_speed;
        int unsigned     k;
        no_speed = ($urandom_range(9) == 0);
        if (dpc_cfg == '0)
            base = 1;
        else
            base = (64'(spacing_cfg) << 16) / 64'(dpc_cfg) + 1;
        t0 = $urandom;
        t = t0;
        push_req(OP_START_LEARN, t0, pick_word(), pick_word(), pick_word());
        for (k = 0; k < n_ticks; k++)
        begin
            if ($urandom_range(24) == 0)
                push_noise();
            else
            begin
                // occasional backward step in the encoder count
                if ($urandom_range(15) == 0)
                    t = t - 32'($urandom_range(1, 32'(base * 2)));
                else
                    t = t + 32'(base * $urandom_range(60, 220) / 100);
                push_req(OP_LEARN_TICK, t, pick_word(), pick_speed(no_speed), pick_word());
            end
        end
        t = t + 32'(base * $urandom_range(0, 150) / 100);
        if ($urandom_range(9) != 0)
            push_req(OP_STOP, t, pick_word(), pick_word(), pick_word());
        travel = t - t0;
        reach = 64'(travel) + 64'(travel) / 2 + 1;
        if (reach > 64'hFFFF_FFFF)
            reach = 64'hFFFF_FFFF;
        r0 = $urandom;
        push_req(OP_START_RACE, r0, pick_word(), pick_word(), pick_word());
        for (k = 0; k < n_queries; k++)
        begin
            if ($urandom_range(29) == 0)
                push_req(OP_STOP, $urandom, pick_word(), pick_word(), pick_word());
            else if ($urandom_range(29) == 0)
            begin
                r0 = $urandom;
                push_req(OP_START_RACE, r0, pick_word(), pick_word(), pick_word());
            end
            if ($urandom_range(6) == 0)
                tq = $urandom;
            else
                tq = r0 + $urandom_range(0, 32'(reach));
            push_req(OP_QUERY, tq, pick_word(), pick_word(), pick_look());
        end
        case ($urandom_range(3))
            0, 1: push_req(OP_STOP, $urandom, pick_word(), pick_word(), pick_word());
            2: push_req(OP_CLEAR, $urandom, pick_word(), pick_word(), pick_word());
            default:
            begin
            end
        endcase
    endtask

    task automatic run_phase(input logic [23:0] dpc, input logic [7:0] spacing,
                             input int unsigned gap, input int unsigned n_items);
        int unsigned stop_at;
        wait_drain();
        write_reg(CFG_DIST_PER_COUNT, dpc);
        write_reg(CFG_SAMPLE_SPACING, {16'b0, spacing});
        gap_pct = gap;
        stop_at = queued_count + n_items;
        while (queued_count < stop_at)
        begin
            if ($urandom_range(7) == 0)
                repeat ($urandom_range(1, 4)) push_noise();
            else
                queue_session($urandom_range(4, 40), $urandom_range(3, 25));
        end
    endtask

    // Zero spacing: every forward tick stores a point, then queries over them
    task automatic run_fill();
        logic [31:0] t;
        logic [31:0] r0;
        int unsigned k;
        wait_drain();
        write_reg(CFG_DIST_PER_COUNT, 24'h00C000);
        write_reg(CFG_SAMPLE_SPACING, 24'h0);
        gap_pct = 20;
        t = $urandom;
        push_req(OP_START_LEARN, t, pick_word(), pick_word(), pick_word());
        for (k = 0; k < 100; k++)
        begin
            if ($urandom_range(49) == 0)
                t = t - 32'($urandom_range(1, 4));
            else
                t = t + 32'($urandom_range(0, 3));
            push_req(OP_LEARN_TICK, t, pick_word(), pick_speed(1'b0), pick_word());
        end
        push_req(OP_STOP, t + 32'($urandom_range(0, 3)), pick_word(), pick_word(), pick_word());
        r0 = $urandom;
        push_req(OP_START_RACE, r0, pick_word(), pick_word(), pick_word());
        for (k = 0; k < 16; k++)
            push_req(OP_QUERY, r0 + $urandom_range(0, 300), pick_word(), pick_word(),
                     pick_look());
        push_req(OP_CLEAR, $urandom, pick_word(), pick_word(), pick_word());
    endtask

    task automatic run_directed();
        wait_drain();
        write_reg(CFG_DIST_PER_COUNT, 24'h010000);
        write_reg(CFG_SAMPLE_SPACING, 24'd10);
        gap_pct = 25;
        // nothing learned yet: query, stop, race and tick do nothing
        push_req(OP_QUERY, 32'h0, 16'h0, 16'h0, 16'h0);
        push_req(OP_STOP, 32'h0, 16'h0, 16'h0, 16'h0);
        push_req(OP_START_RACE, 32'h0, 16'h0, 16'h0, 16'h0);
        push_req(OP_LEARN_TICK, 32'h100, 16'h0, 16'h100, 16'h0);
        // learn across the counter wrap, 1 cm per count
        push_req(OP_START_LEARN, 32'hFFFF_FFF0, 16'h0, 16'h0, 16'h0);
        push_req(OP_LEARN_TICK, 32'hFFFF_FFF5, 16'h0, 16'h100, 16'h0);
        push_req(OP_LEARN_TICK, 32'h0000_0000, 16'h8000, 16'h7FFF, 16'h0);
        push_req(OP_LEARN_TICK, 32'hFFFF_FFF0, 16'h0, 16'h100, 16'h0);
        push_req(OP_LEARN_TICK, 32'h0000_0010, 16'h7FFF, 16'h8000, 16'hFFFF);
        push_req(OP_LEARN_TICK, 32'h0000_0020, 16'hFFF7, 16'd26, 16'h0);
        push_req(OP_LEARN_TICK, 32'h0000_0030, 16'h0, 16'h0, 16'h0);
        push_req(OP_LEARN_TICK, 32'h0000_0040, 16'd8, 16'd256, 16'h0);
        push_req(OP_STOP, 32'h0000_0050, 16'h0, 16'h0, 16'h0);
        // race queries, look-ahead wrapping past the lap
        push_req(OP_START_RACE, 32'h0, 16'h0, 16'h0, 16'h0);
        push_req(OP_QUERY, 32'h0, 16'h0, 16'h0, 16'h0);
        push_req(OP_QUERY, 32'd100, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_req(OP_QUERY, 32'hFFFF_FFFF, 16'h0, 16'h0, 16'd50);
        push_req(OP_STOP, 32'h0, 16'h0, 16'h0, 16'h0);
        push_req(OP_QUERY, 32'h0, 16'h0, 16'h0, 16'h0);
        push_req(OP_START_RACE, 32'd7, 16'h0, 16'h0, 16'h0);
        push_req(OP_CLEAR, 32'h0, 16'h0, 16'h0, 16'h0);
        push_req(OP_QUERY, 32'h0, 16'h0, 16'h0, 16'h0);
        // two points but a zero lap: race starts, queries refused
        push_req(OP_START_LEARN, 32'd1000, 16'h0, 16'h0, 16'h0);
        push_req(OP_LEARN_TICK, 32'd1020, 16'h1234, 16'h0400, 16'h0);
        push_req(OP_LEARN_TICK, 32'd1040, 16'hEDCB, 16'h0300, 16'h0);
        push_req(OP_STOP, 32'd1000, 16'h0, 16'h0, 16'h0);
        push_req(OP_START_RACE, 32'd5, 16'h0, 16'h0, 16'h0);
        push_req(OP_QUERY, 32'd5, 16'h0, 16'h0, 16'd10);
    endtask

    // Stimulus sequence
    initial
    begin
        rst_n = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.req = '0;
        result_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.req = '0;
        queued_count = 0;
        taken_count = 0;
        err_count = 0;
        cycle_count = 0;
        gap_pct = 0;
        prof_mode = MODE_IDLE;
        prof_count = '0;
        prof_lap = '0;
        prof_start = '0;
        prof_last = '0;
        dpc_cfg = '0;
        spacing_cfg = 8'd10;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();
        run_phase(24'h010000, 8'd10, 0, 80);
        run_phase(24'h000001, 8'd1, 30, 70);
        run_phase(24'hFFFFFF, 8'd255, 50, 80);
        run_phase(24'h000000, 8'd20, 30, 30);
        run_fill();
        repeat (3)
            run_phase(24'($urandom_range(24'h002000, 24'h060000)),
                      8'($urandom_range(1, 255)), 40, 90);

        wait_drain();
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== distance_profile_learn_and_lookup_unit.f =====
hw/rtl/dpl_pkg.sv
hw/rtl/dpl_item_if.sv
hw/rtl/dpl_result_if.sv
hw/rtl/dpl_cfg_if.sv
hw/rtl/dpl_point_mem.sv
hw/rtl/dpl_rem_unit.sv
hw/rtl/distance_profile_learn_and_lookup_unit.sv
sim/distance_profile_learn_and_lookup_unit_test.sv
